### rtl/core/lruht_pkg.sv
// ----------------------------------------------------------------------------
// LRU open handle tracker package
// Shared defaults and the command bundle from the controller to the datapath.
// ----------------------------------------------------------------------------
package lruht_pkg;

   localparam int CAPACITY_DEFAULT = 8;
   localparam int ID_BITS_DEFAULT  = 16;
   localparam int SESSION_BITS     = 16;

   typedef struct packed {
      logic load;     // capture the accepted session identifier
      logic compare;  // compare it against every tracked entry
      logic update;   // reorder the entries and issue the result
   } lruht_cmd_type;

endpackage

### rtl/core/lruht_ctrl.sv
// ----------------------------------------------------------------------------
// LRU open handle tracker controller
// Sequences one item through load, compare and update.
// ----------------------------------------------------------------------------
module lruht_ctrl (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   output logic                     busy,
   output lruht_pkg::lruht_cmd_type cmd
);

   localparam logic [1:0] ST_IDLE    = 2'd0;
   localparam logic [1:0] ST_COMPARE = 2'd1;
   localparam logic [1:0] ST_UPDATE  = 2'd2;

   logic [1:0] state_ff;
   logic [1:0] state_in;

   always_comb begin
      state_in    = state_ff;
      cmd         = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               state_in = ST_COMPARE;
            end
         end
         ST_COMPARE: begin
            cmd.compare = 1'b1;
            state_in    = ST_UPDATE;
         end
         ST_UPDATE: begin
            cmd.update = 1'b1;
            state_in   = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign busy = (state_ff != ST_IDLE);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

### rtl/core/lruht_datapath.sv
// ----------------------------------------------------------------------------
// LRU open handle tracker datapath
// Recency shift line, parallel compare, occupancy count and result register.
// ----------------------------------------------------------------------------
module lruht_datapath #(
   parameter int CAPACITY = lruht_pkg::CAPACITY_DEFAULT,
   parameter int ID_BITS  = lruht_pkg::ID_BITS_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  lruht_pkg::lruht_cmd_type            cmd,
   input  logic [lruht_pkg::SESSION_BITS-1:0]  req_session_id,
   output logic                                rsp_valid,
   output logic                                rsp_hit,
   output logic                                rsp_evict_valid,
   output logic [lruht_pkg::SESSION_BITS-1:0]  rsp_evicted_session
);

   localparam int OCC_BITS  = $clog2(CAPACITY + 1);
   localparam int LOAD_BITS = (ID_BITS < lruht_pkg::SESSION_BITS) ? ID_BITS
                                                                  : lruht_pkg::SESSION_BITS;
   localparam logic [OCC_BITS-1:0] OCC_FULL = OCC_BITS'(CAPACITY);

   logic [ID_BITS-1:0]  sid_ff;
   logic [ID_BITS-1:0]  entry_ff [CAPACITY];
   logic [ID_BITS-1:0]  entry_in [CAPACITY];
   logic [OCC_BITS-1:0] occ_ff;
   logic [OCC_BITS-1:0] occ_in;
   logic [CAPACITY-1:0] match_ff;
   logic [CAPACITY-1:0] match_in;
   logic [CAPACITY-1:0] at_or_below_match;
   logic                hit;
   logic                full;

   logic                                rsp_valid_ff;
   logic                                rsp_hit_ff;
   logic                                rsp_evict_valid_ff;
   logic [lruht_pkg::SESSION_BITS-1:0]  rsp_evicted_session_ff;

   // Only entries below the occupancy count take part in the compare.
   for (genvar k = 0; k < CAPACITY; k++) begin : g_match
      assign match_in[k] = (entry_ff[k] == sid_ff) && (OCC_BITS'(k) < occ_ff);
   end

   assign hit  = |match_ff;
   assign full = (occ_ff == OCC_FULL);

   // Tracked identifiers are unique, so the match vector is one-hot or zero.
   // One less than it sets every position below the match; or-ing the match
   // back in marks every position at or below it.
   assign at_or_below_match = match_ff | (match_ff - CAPACITY'(1));

   always_comb begin
      entry_in = entry_ff;
      occ_in   = occ_ff;
      if (cmd.update) begin
         entry_in[0] = sid_ff;
         for (int k = 1; k < CAPACITY; k++) begin
            if (!hit || at_or_below_match[k]) begin
               entry_in[k] = entry_ff[k-1];
            end
         end
         if (!hit && !full) begin
            occ_in = occ_ff + OCC_BITS'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         sid_ff <= ID_BITS'(req_session_id[LOAD_BITS-1:0]);
      end
      if (cmd.compare) begin
         match_ff <= match_in;
      end
      entry_ff <= entry_in;
      if (cmd.update) begin
         rsp_hit_ff             <= hit;
         rsp_evict_valid_ff     <= !hit && full;
         rsp_evicted_session_ff <= (!hit && full)
            ? lruht_pkg::SESSION_BITS'(entry_ff[CAPACITY-1][LOAD_BITS-1:0])
            : '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         occ_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         occ_ff       <= occ_in;
         rsp_valid_ff <= cmd.update;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_hit             = rsp_hit_ff;
   assign rsp_evict_valid     = rsp_evict_valid_ff;
   assign rsp_evicted_session = rsp_evicted_session_ff;

   a_occ_bounded: assert property (@(posedge clock) disable iff (reset)
      occ_ff <= OCC_FULL)
      else $error("occupancy exceeds capacity");

   a_match_unique: assert property (@(posedge clock) disable iff (reset)
      cmd.update |-> $onehot0(match_ff))
      else $error("session tracked more than once");

   a_evict_needs_full: assert property (@(posedge clock) disable iff (reset)
      cmd.update && !hit && full |=> rsp_evict_valid && $stable(occ_ff))
      else $error("miss while full did not evict");

   a_rsp_after_update: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(cmd.update))
      else $error("result strobe without an update");

endmodule

### rtl/core/lru_open_handle_tracker_unit.sv
// ----------------------------------------------------------------------------
// LRU open handle tracker
// Keeps the most recently accessed sessions in recency order and reports hits
// and evictions.
// ----------------------------------------------------------------------------
// The accepted item is captured at the accepting edge, compared in the compare
// state, and its result is registered at the end of the update state.
// A new item is accepted only in the idle state; busy covers the compare and
// update states, so the tracker takes no new item before the last one is through.
// Reset clears the occupancy count and the result strobe; the tracker is then
// empty. Results cannot be stalled and are valid for exactly one cycle.
module lru_open_handle_tracker_unit #(
   parameter int CAPACITY = lruht_pkg::CAPACITY_DEFAULT,
   parameter int ID_BITS  = lruht_pkg::ID_BITS_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  logic [lruht_pkg::SESSION_BITS-1:0]  req_session_id,
   output logic                                rsp_valid,
   output logic                                rsp_hit,
   output logic                                rsp_evict_valid,
   output logic [lruht_pkg::SESSION_BITS-1:0]  rsp_evicted_session
);

   lruht_pkg::lruht_cmd_type cmd;

   lruht_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .busy  (busy),
      .cmd   (cmd)
   );

   lruht_datapath #(
      .CAPACITY (CAPACITY),
      .ID_BITS  (ID_BITS)
   ) u_datapath (
      .clock               (clock),
      .reset               (reset),
      .cmd                 (cmd),
      .req_session_id      (req_session_id),
      .rsp_valid           (rsp_valid),
      .rsp_hit             (rsp_hit),
      .rsp_evict_valid     (rsp_evict_valid),
      .rsp_evicted_session (rsp_evicted_session)
   );

endmodule

### tb/sv/lru_tracker_checker.sv
// ----------------------------------------------------------------------------
// LRU open handle tracker checker
// Watches the request and response channels of the tracker and keeps its own
// copy of the recency list. It predicts one result per accepted item and
// compares every response against the oldest prediction still outstanding.
// ----------------------------------------------------------------------------
module lru_tracker_checker #(
   parameter int CAPACITY = lruht_pkg::CAPACITY_DEFAULT,
   parameter int ID_BITS  = lruht_pkg::ID_BITS_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   input  logic                                busy,
   input  logic [lruht_pkg::SESSION_BITS-1:0]  req_session_id,
   input  logic                                rsp_valid,
   input  logic                                rsp_hit,
   input  logic                                rsp_evict_valid,
   input  logic [lruht_pkg::SESSION_BITS-1:0]  rsp_evicted_session,
   output int                                  mismatch_count,
   output int                                  pending
);

   import lruht_pkg::SESSION_BITS;

   typedef struct packed {
      logic                    hit;
      logic                    evict_valid;
      logic [SESSION_BITS-1:0] evicted_session;
   } access_result_type;

   logic [ID_BITS-1:0] recency [CAPACITY];
   int                 tracked;
   access_result_type  access_results_due [$];

   // Updates the local recency list for one access and returns its result.
   function automatic access_result_type predict_access(
      input logic [SESSION_BITS-1:0] session_id);
      logic [ID_BITS-1:0] key;
      int                 found;
      int                 slot;
      access_result_type  res;
      key   = ID_BITS'(session_id);
      found = -1;
      res   = '0;
      for (int i = 0; i < tracked; i++) begin
         if (found < 0 && recency[i] == key) begin
            found = i;
         end
      end
      if (found >= 0) begin
         res.hit = 1'b1;
         slot    = found;
      end else if (tracked == CAPACITY) begin
         res.evict_valid     = 1'b1;
         res.evicted_session = SESSION_BITS'(recency[CAPACITY-1]);
         slot                = CAPACITY - 1;
      end else begin
         slot    = tracked;
         tracked = tracked + 1;
      end
      // Everything ahead of the freed slot moves back by one place.
      for (int k = slot; k > 0; k--) begin
         recency[k] = recency[k-1];
      end
      recency[0] = key;
      return res;
   endfunction

   task automatic note_failure(input string what, input access_result_type want,
                               input access_result_type got);
      mismatch_count = mismatch_count + 1;
      if (mismatch_count <= 10) begin
         $display("%s: expected hit=%0b evict_valid=%0b evicted=%h,",
                  what, want.hit, want.evict_valid, want.evicted_session,
                  " got hit=%0b evict_valid=%0b evicted=%h",
                  got.hit, got.evict_valid, got.evicted_session);
      end
   endtask

   always @(posedge clock) begin
      access_result_type got;
      access_result_type want;
      if (reset) begin
         tracked        = 0;
         mismatch_count = 0;
         access_results_due.delete();
      end else begin
         if (rsp_valid) begin
            got = {rsp_hit, rsp_evict_valid, rsp_evicted_session};
            if (access_results_due.size() == 0) begin
               note_failure("response with no item outstanding", '0, got);
            end else begin
               want = access_results_due.pop_front();
               if (got !== want) begin
                  note_failure("response mismatch", want, got);
               end
            end
         end
         if (start && !busy) begin
            access_results_due.push_back(predict_access(req_session_id));
         end
      end
      pending = access_results_due.size();
   end

endmodule

### tb/sv/tb_lru_open_handle_tracker_unit.sv
// ----------------------------------------------------------------------------
// LRU open handle tracker testbench
// Drives session accesses into the tracker with random gaps: a directed run
// over hits at the front and back, fills and evictions, then random bursts
// drawn from small session pools so that hits and evictions both occur often.
// ----------------------------------------------------------------------------
module tb_lru_open_handle_tracker_unit;

   import lruht_pkg::*;

   localparam int ITEM_TARGET = 450;
   localparam int IDLE_LIMIT  = 2000;
   localparam int DIRECTED_N  = 14;

   logic                    clock;
   logic                    reset;
   logic                    start;
   logic                    busy;
   logic [SESSION_BITS-1:0] req_session_id;
   logic                    rsp_valid;
   logic                    rsp_hit;
   logic                    rsp_evict_valid;
   logic [SESSION_BITS-1:0] rsp_evicted_session;
   int                      mismatch_count;
   int                      pending;
   int                      idle_cycles;

   // Fills the tracker, hits the front and the back, then evicts twice.
   logic [SESSION_BITS-1:0] directed_ids [DIRECTED_N] = '{
      16'h0000, 16'h0000, 16'hFFFF, 16'h0000, 16'h1234, 16'h8001, 16'h5555,
      16'hAAAA, 16'h7FFE, 16'h0001, 16'hFFFF, 16'h4321, 16'hFFFE, 16'hFFFE
   };

   lru_open_handle_tracker_unit u_top (
      .clock               (clock),
      .reset               (reset),
      .start               (start),
      .busy                (busy),
      .req_session_id      (req_session_id),
      .rsp_valid           (rsp_valid),
      .rsp_hit             (rsp_hit),
      .rsp_evict_valid     (rsp_evict_valid),
      .rsp_evicted_session (rsp_evicted_session)
   );

   lru_tracker_checker u_checker (
      .clock               (clock),
      .reset               (reset),
      .start               (start),
      .busy                (busy),
      .req_session_id      (req_session_id),
      .rsp_valid           (rsp_valid),
      .rsp_hit             (rsp_hit),
      .rsp_evict_valid     (rsp_evict_valid),
      .rsp_evicted_session (rsp_evicted_session),
      .mismatch_count      (mismatch_count),
      .pending             (pending)
   );

   initial clock = 1'b0;
   always #10 clock = ~clock;

   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("tb_lru_open_handle_tracker_unit: done, errors");
         $finish;
      end
   end

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) begin
         return 0;
      end else if (r < 85) begin
         return $urandom_range(1, 3);
      end else if (r < 97) begin
         return $urandom_range(4, 8);
      end
      return $urandom_range(15, 40);
   endfunction

   // Presents one item at a falling edge and holds it until it is taken.
   task automatic access_session(input logic [SESSION_BITS-1:0] session_id, input int gap);
      req_session_id <= session_id;
      start          <= 1'b1;
      do @(posedge clock); while (busy);
      @(negedge clock);
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(negedge clock);
      end
   endtask

   task automatic drain_tracker();
      start <= 1'b0;
      @(negedge clock);
      wait (pending == 0);
      @(negedge clock);
   endtask

   initial begin
      int                      sent;
      int                      phase_left;
      int                      pool_size;
      logic [SESSION_BITS-1:0] pool_base;
      logic [SESSION_BITS-1:0] session_id;
      bit                      noisy_phase;
      bit                      quiet_phase;
      bit                      drained;
      reset          <= 1'b1;
      start          <= 1'b0;
      req_session_id <= '0;
      repeat (2) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      foreach (directed_ids[i]) begin
         access_session(directed_ids[i], pick_gap());
      end
      drain_tracker();

      sent       = 0;
      phase_left = 0;
      drained    = 1'b0;
      while (sent < ITEM_TARGET) begin
         if (phase_left == 0) begin
            phase_left  = $urandom_range(15, 50);
            pool_size   = $urandom_range(2, 14);
            pool_base   = SESSION_BITS'($urandom);
            noisy_phase = ($urandom_range(0, 4) == 0);
            quiet_phase = ($urandom_range(0, 3) == 0);
         end
         if (noisy_phase || $urandom_range(0, 9) == 0) begin
            session_id = SESSION_BITS'($urandom);
         end else begin
            session_id = pool_base + SESSION_BITS'($urandom_range(0, pool_size - 1));
         end
         access_session(session_id, quiet_phase ? 0 : pick_gap());
         sent       = sent + 1;
         phase_left = phase_left - 1;
         if (!drained && sent >= ITEM_TARGET / 2) begin
            drain_tracker();
            drained = 1'b1;
         end
      end

      start <= 1'b0;
      wait (pending == 0);
      repeat (8) @(posedge clock);
      if (mismatch_count == 0 && pending == 0) begin
         $display("tb_lru_open_handle_tracker_unit: done, clean");
      end else begin
         $display("tb_lru_open_handle_tracker_unit: done, errors");
      end
      $finish;
   end

endmodule

### sim.f
rtl/core/lruht_pkg.sv
rtl/core/lruht_ctrl.sv
rtl/core/lruht_datapath.sv
rtl/core/lru_open_handle_tracker_unit.sv
tb/sv/lru_tracker_checker.sv
tb/sv/tb_lru_open_handle_tracker_unit.sv
